// File: hw/rtl/fti_pkg.sv
// fti_pkg: shared constants, types and tables of the tilt fir block
// holds the coefficient table and the led map; no dependencies
package fti_pkg;

    localparam int TAP_COUNT_DEF = 49;
    localparam int SAMPLE_W      = 17;
    localparam int COEF_W        = 13;
    localparam int PROD_W        = SAMPLE_W + COEF_W;
    localparam int ACC_W         = 40;
    localparam int RAW_W         = 16;
    localparam int OFFSET_W      = 8;
    localparam int SHIFT_W       = 5;
    localparam int FILT_W        = 32;
    localparam int LED_W         = 8;
    localparam int LEVEL_W       = 5;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_SHIFT    = 2'd1;

    localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = -8'sd32;
    localparam logic [SHIFT_W-1:0]         SHIFT_RESET  = 5'd12;

    typedef struct packed {
        logic clear;
        logic data_valid;
    } mac_ctrl_t;

    // tap weight, index 0 weights the oldest sample
    function automatic logic signed [COEF_W-1:0] tap_coef(input int idx);
        logic signed [COEF_W-1:0] c;
        case (idx)
            0:  c = 13'sd19;
            1:  c = 13'sd30;
            2:  c = -13'sd10;
            3:  c = -13'sd29;
            4:  c = 13'sd13;
            5:  c = 13'sd0;
            6:  c = -13'sd38;
            7:  c = 13'sd16;
            8:  c = 13'sd18;
            9:  c = -13'sd55;
            10: c = 13'sd12;
            11: c = 13'sd47;
            12: c = -13'sd73;
            13: c = -13'sd4;
            14: c = 13'sd91;
            15: c = -13'sd92;
            16: c = -13'sd45;
            17: c = 13'sd162;
            18: c = -13'sd108;
            19: c = -13'sd138;
            20: c = 13'sd308;
            21: c = -13'sd118;
            22: c = -13'sd493;
            23: c = 13'sd1179;
            24: c = 13'sd2609;
            25: c = 13'sd1179;
            26: c = -13'sd493;
            27: c = -13'sd118;
            28: c = 13'sd308;
            29: c = -13'sd138;
            30: c = -13'sd108;
            31: c = 13'sd162;
            32: c = -13'sd45;
            33: c = -13'sd92;
            34: c = 13'sd91;
            35: c = -13'sd4;
            36: c = -13'sd73;
            37: c = 13'sd47;
            38: c = 13'sd12;
            39: c = -13'sd55;
            40: c = 13'sd18;
            41: c = 13'sd16;
            42: c = -13'sd38;
            43: c = 13'sd0;
            44: c = 13'sd13;
            45: c = -13'sd29;
            46: c = -13'sd10;
            47: c = 13'sd30;
            48: c = 13'sd19;
            default: c = 13'sd0;
        endcase
        return c;
    endfunction

    function automatic logic [LED_W-1:0] led_map(input logic [2:0] sel);
        logic [LED_W-1:0] p;
        case (sel)
            3'd0: p = 8'h08;
            3'd1: p = 8'h04;
            3'd2: p = 8'h02;
            3'd3: p = 8'h01;
            3'd4: p = 8'h80;
            3'd5: p = 8'h40;
            3'd6: p = 8'h20;
            3'd7: p = 8'h10;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

endpackage

// File: hw/rtl/fti_line_mem.sv
// fti_line_mem: circular sample delay line, one write and one registered read port
// uses fti_pkg; per-entry valid bits make unwritten entries read as zero after reset
module fti_line_mem
    import fti_pkg::*;
#(
    parameter int DEPTH  = TAP_COUNT_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic signed [SAMPLE_W-1:0] wdata,
    input  logic                       re,
    input  logic [ADDR_W-1:0]          raddr,
    output logic signed [SAMPLE_W-1:0] rdata
);

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]           valid_reg;
    logic signed [SAMPLE_W-1:0] rdata_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (we)
        begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= valid_reg[raddr] ? mem[raddr] : '0;
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/fti_mac.sv
// fti_mac: multiply by tap weight, register product, then accumulate
// uses fti_pkg for the coefficient table and mac_ctrl_t
module fti_mac
    import fti_pkg::*;
#(
    parameter int ADDR_W = $clog2(TAP_COUNT_DEF)
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  mac_ctrl_t                  ctrl,
    input  logic signed [SAMPLE_W-1:0] sample,
    input  logic [ADDR_W-1:0]          coef_idx,
    output logic                       busy,
    output logic signed [ACC_W-1:0]    acc
);

    logic signed [COEF_W-1:0] coef_val;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_v_reg;
    logic signed [ACC_W-1:0]  acc_reg;

    assign coef_val = tap_coef(int'(coef_idx));
    assign prod     = sample * coef_val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_v_reg <= 1'b0;
        end
        else
        begin
            prod_v_reg <= ctrl.data_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.data_valid)
        begin
            prod_reg <= prod;
        end
        if (ctrl.clear)
        begin
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    assign busy = prod_v_reg;
    assign acc  = acc_reg;

endmodule

// File: hw/rtl/fir_tilt_led_indicator_core.sv
// fir_tilt_led_indicator_core: 49-tap fir over accelerometer samples driving a tilt led byte
// uses fti_pkg, fti_line_mem and fti_mac
//
// usage:
//   s_tvalid/s_tready/s_tdata carry one raw sample word (tdata[15:0], signed).
//   m_tvalid/m_tready/m_tdata carry one result word per sample.
//   cfg_we/cfg_index/cfg_data write sample_offset (index 0) or gain_shift (index 1);
//   other indexes are ignored. write only while the block is idle.
// timing:
//   a sample is taken and stored in the delay line, then the 49 taps are read
//   from the line memory one per cycle through a single multiplier and accumulator; each
//   tap passes the line memory read register, the product register and the accumulator.
//   the next sample is accepted once the result is loaded into the output register, so
//   no new sample is taken while one is still being filtered.
// reset:
//   the delay line reads as all zeros, the write pointer is zero, the registers
//   take their reset values (offset -32, shift 12) and no result is pending.
// stall:
//   a result waits in the output register; a finished sum waits until that register
//   is free, and no new sample is taken meanwhile.
module fir_tilt_led_indicator_core
    import fti_pkg::*;
#(
    parameter int TAP_COUNT = TAP_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [15:0]           s_tdata,   // raw_sample[15:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,   // filtered_value[31:0], led_byte[39:32],
                                             // tilt_level[44:40], zero[47:45]
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(TAP_COUNT);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TAP_COUNT - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN
    } state_t;

    state_t                      state_reg, state_next;
    logic [ADDR_W-1:0]           wp_reg, wp_next;
    logic [ADDR_W-1:0]           ra_reg, ra_next;
    logic [ADDR_W-1:0]           k_reg, k_next;
    logic [ADDR_W-1:0]           kd_reg, kd_next;
    logic                        rd_v_reg, rd_v_next;
    logic signed [OFFSET_W-1:0]  offset_reg;
    logic [SHIFT_W-1:0]          shift_reg;
    logic                        out_valid_reg, out_valid_next;
    logic [47:0]                 out_data_reg, out_data_next;

    logic                        accept;
    logic                        mem_re;
    logic signed [SAMPLE_W-1:0]  new_sample;
    logic signed [SAMPLE_W-1:0]  rd_sample;
    logic signed [ACC_W-1:0]     acc;
    logic signed [ACC_W-1:0]     shifted;
    logic [FILT_W-1:0]           filt;
    logic                        mac_busy;
    logic                        done;
    mac_ctrl_t                   mac_ctrl;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign mem_re   = (state_reg == S_RUN);

    assign new_sample = $signed({s_tdata[RAW_W-1], s_tdata})
                      + $signed({{(SAMPLE_W-OFFSET_W){offset_reg[OFFSET_W-1]}}, offset_reg});

    assign mac_ctrl.clear      = accept;
    assign mac_ctrl.data_valid = rd_v_reg;

    fti_line_mem #(
        .DEPTH  (TAP_COUNT),
        .ADDR_W (ADDR_W)
    ) u_line (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (accept),
        .waddr (wp_reg),
        .wdata (new_sample),
        .re    (mem_re),
        .raddr (ra_reg),
        .rdata (rd_sample)
    );

    fti_mac #(
        .ADDR_W (ADDR_W)
    ) u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mac_ctrl),
        .sample   (rd_sample),
        .coef_idx (kd_reg),
        .busy     (mac_busy),
        .acc      (acc)
    );

    // arithmetic shift of the full sum, low 32 bits kept
    assign shifted = acc >>> shift_reg;
    assign filt    = shifted[FILT_W-1:0];

    assign done = (state_reg == S_DRAIN) && !rd_v_reg && !mac_busy
               && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        ra_next        = ra_reg;
        k_next         = k_reg;
        kd_next        = kd_reg;
        rd_v_next      = 1'b0;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    wp_next    = (wp_reg == LAST_ADDR) ? '0 : wp_reg + 1'b1;
                    // oldest sample sits right after the one just written
                    ra_next    = wp_next;
                    k_next     = '0;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                rd_v_next = 1'b1;
                kd_next   = k_reg;
                ra_next   = (ra_reg == LAST_ADDR) ? '0 : ra_reg + 1'b1;
                k_next    = k_reg + 1'b1;
                if (k_reg == LAST_ADDR)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (done)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000, filt[LEVEL_W:1], led_map(filt[8:6]), filt};
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wp_reg        <= '0;
            ra_reg        <= '0;
            k_reg         <= '0;
            kd_reg        <= '0;
            rd_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            ra_reg        <= ra_next;
            k_reg         <= k_next;
            kd_reg        <= kd_next;
            rd_v_reg      <= rd_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= OFFSET_RESET;
            shift_reg  <= SHIFT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SAMPLE_OFFSET: offset_reg <= $signed(cfg_data[OFFSET_W-1:0]);
                CFG_GAIN_SHIFT:    shift_reg  <= cfg_data[SHIFT_W-1:0];
                default:           ;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
